[rtl/core/sjd_pkg.sv]
// ----------------------------------------------------------------------------
// Skeleton junction detector package
// Register map, reset values and the 3x3 neighbourhood tests.
// ----------------------------------------------------------------------------
`default_nettype none

package sjd_pkg;

  // Register map (word index on the configuration port)
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } sjd_reg_e;

  localparam int unsigned MaxWidthDefault = 1024;

  localparam logic [7:0]  ThresholdReset = 8'd100;
  localparam logic [10:0] WidthReset     = 11'd640;
  localparam logic [15:0] HeightReset    = 16'd480;

  // Smallest frame that has an inner pixel
  localparam logic [15:0] MinHeight = 16'd3;
  localparam logic [10:0] MinWidth  = 11'd3;

  // Window bit k sits at row k/3, column k%3; bit 4 is the centre.
  // Neighbour layout 1 2 3 / 4 . 6 / 7 8 9.
  function automatic logic sjd_match(input logic [8:0] w);
    logic n1, n2, n3, n4, n6, n7, n8, n9;
    logic hit;
    n1 = w[0]; n2 = w[1]; n3 = w[2];
    n4 = w[3]; n6 = w[5];
    n7 = w[6]; n8 = w[7]; n9 = w[8];
    hit = (n1 & n3 & n7 & ~n2 & ~n4)
        | (n1 & n3 & n8 & ~n2)
        | (n1 & n3 & n9 & ~n2 & ~n6)
        | (n1 & n6 & n7 & ~n4)
        | (n1 & n6 & n8)
        | (n1 & n7 & n9 & ~n4 & ~n8)
        | (n2 & n4 & n6)
        | (n2 & n4 & n8)
        | (n2 & n4 & n9)
        | (n2 & n6 & n7)
        | (n2 & n6 & n8)
        | (n2 & n7 & n9 & ~n8)
        | (n3 & n4 & n8)
        | (n3 & n4 & n9 & ~n6)
        | (n3 & n7 & n9 & ~n6 & ~n8)
        | (n4 & n6 & n8);
    return hit;
  endfunction

  // Foreground count among the eight neighbours
  function automatic logic [3:0] sjd_count(input logic [8:0] w);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        n = n + {3'd0, w[k]};
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/core/skeleton_junction_detector.sv]
// ----------------------------------------------------------------------------
// Skeleton junction detector
// Binarises a raster pixel stream and flags junction points of a one-pixel
// skeleton from a 3x3 window built on two single-bit line memories.
// ----------------------------------------------------------------------------
// Pipeline: an item's line memory read is issued on the accepting edge; the
//   window and pattern test follow in stage 1, which loads the result into
//   the output register when it advances, and the result leaves from there.
// Throughput: one item per cycle unless a result meets a full output, set by
//   one read and one write port per line memory; a read-modify-write of column c per item.
// Reset: rst_ni clears counters, window, pipeline valids and loads the
//   register defaults (threshold 100, 640 x 480). Line memories are not
//   cleared; unwritten entries only reach border centres.
`default_nettype none

module skeleton_junction_detector
  import sjd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Pixel stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] gray_pixel
  input  wire logic        s_axis_tuser,   // [0] frame_start

  // Result stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [0] is_junction, [4:1] neighbour_count,
                                           // [20:5] centre_row, [30:21] centre_col,
                                           // [31] zero

  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CWP = $clog2(MAX_WIDTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  threshold_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic        cfg_wr;
  sjd_reg_e    cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_reg = sjd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      width_q     <= WidthReset;
      height_q    <= HeightReset;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_THRESHOLD: threshold_q <= pwdata[7:0];
        REG_WIDTH:     width_q     <= pwdata[10:0];
        REG_HEIGHT:    height_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_THRESHOLD: prdata = {24'd0, threshold_q};
      REG_WIDTH:     prdata = {21'd0, width_q};
      REG_HEIGHT:    prdata = {16'd0, height_q};
      default:       prdata = 32'd0;
    endcase
  end

  // Effective geometry: width clamped to 3..MAX_WIDTH, height to at least 3
  logic [CWP-1:0] eff_w;
  logic [15:0]    eff_h;

  always_comb begin
    if (width_q < MinWidth) begin
      eff_w = CWP'(MinWidth);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = CWP'(MAX_WIDTH);
    end else begin
      eff_w = CWP'(width_q);
    end
    eff_h = (height_q < MinHeight) ? MinHeight : height_q;
  end

  // --------------------------------------------------------------------------
  // Intake: position, binarise, issue the line memory read
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [CW-1:0] c0;
  logic [15:0]   r0;
  logic          cur0;
  logic          emit0;
  logic          border0;
  logic          in_acc;

  // Pipeline stage 1: item whose memory read is in flight
  logic          s1_valid_q;
  logic          s1_emit_q;
  logic          s1_border_q;
  logic          s1_cur_q;
  logic [CW-1:0] s1_c_q;
  logic [15:0]   s1_cr_q;
  logic [CW-1:0] s1_cc_q;
  logic          s1_fwd_q;
  logic          s1_fwd_up_q;
  logic          s1_fwd_mid_q;
  logic          s1_adv;

  logic          rd_up_q;
  logic          rd_mid_q;
  logic          up_eff;
  logic          mid_eff;

  logic          mem_upper  [MAX_WIDTH];
  logic          mem_middle [MAX_WIDTH];

  logic [8:0]    win_q, win_d;
  logic          out_valid_q;
  logic          out_junc_q;
  logic [3:0]    out_count_q;
  logic [15:0]   out_row_q;
  logic [9:0]    out_col_q;
  logic          junc1;

  assign in_acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    r0      = s_axis_tuser ? 16'd0 : row_q;
    c0      = s_axis_tuser ? '0 : col_q;
    cur0    = (s_axis_tdata <= threshold_q);
    emit0   = (r0 != 16'd0) && (c0 != '0);
    // Centre (r0-1, c0-1) is border when on the first or last row/column
    border0 = (r0 == 16'd1) || (c0 == CW'(1)) || (r0 >= eff_h) ||
              (CWP'(c0) >= eff_w);
    // Advance to the next pixel position
    if ((CWP'(c0) + CWP'(1)) >= eff_w) begin
      col_d = '0;
      row_d = ((17'(r0) + 17'd1) >= 17'(eff_h)) ? 16'd0 : r0 + 16'd1;
    end else begin
      col_d = c0 + CW'(1);
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= 16'd0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: read data back, forward the previous write when it hit the
  // same column, write back the shifted column and update the window
  // --------------------------------------------------------------------------
  // An item leaves stage 1 unless it has a result and the output is full
  assign s1_adv        = s1_valid_q & (~s1_emit_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_adv;

  assign up_eff  = s1_fwd_q ? s1_fwd_up_q  : rd_up_q;
  assign mid_eff = s1_fwd_q ? s1_fwd_mid_q : rd_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q    <= emit0;
      s1_border_q  <= border0;
      s1_cur_q     <= cur0;
      s1_c_q       <= c0;
      s1_cr_q      <= r0 - 16'd1;
      s1_cc_q      <= c0 - CW'(1);
      // Read and write of one column in the same cycle: take the new data
      s1_fwd_q     <= s1_adv && (s1_c_q == c0);
      s1_fwd_up_q  <= mid_eff;
      s1_fwd_mid_q <= s1_cur_q;
    end
  end

  // Line memories: one read port, one write port each
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_up_q  <= mem_upper[c0];
      rd_mid_q <= mem_middle[c0];
    end
    if (s1_adv) begin
      mem_upper[s1_c_q]  <= mid_eff;
      mem_middle[s1_c_q] <= s1_cur_q;
    end
  end

  always_comb begin
    win_d = ((win_q >> 1) & 9'h0DB) | (9'(up_eff) << 2) | (9'(mid_eff) << 5) |
            (9'(s1_cur_q) << 8);
    junc1 = ~s1_border_q & win_d[4] & sjd_match(win_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 9'd0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_junc_q  <= junc1;
      out_count_q <= junc1 ? sjd_count(win_d) : 4'd0;
      out_row_q   <= s1_cr_q;
      out_col_q   <= 10'(s1_cc_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_col_q, out_row_q, out_count_q, out_junc_q};

endmodule

`default_nettype wire
